// ===== sv/capture_period_speed_meter_assert.svh =====
// Assertion macros for the capture period speed meter.
`ifndef CAPTURE_PERIOD_SPEED_METER_ASSERT_SVH
`define CAPTURE_PERIOD_SPEED_METER_ASSERT_SVH
`ifndef ASSERT_OFF
// Same-cycle implication, checked outside reset.
`define CSM_ASSERT_IMP(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("same-cycle implication failed");
// Next-cycle implication, checked outside reset.
`define CSM_ASSERT_NXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle implication failed");
`else
`define CSM_ASSERT_IMP(lbl, clk, rst, ante, cons)
`define CSM_ASSERT_NXT(lbl, clk, rst, ante, cons)
`endif
`endif

// ===== sv/csm_pkg.sv =====
// Shared widths and constants of the capture period speed meter.
`default_nettype none
package csm_pkg;
  localparam int CAP_W              = 16;
  localparam int SCALE_W            = 22;
  localparam int TIMER_BITS_DEFAULT = 16;
  localparam logic [SCALE_W-1:0] SCALE_RESET = 22'd3003003;
  localparam logic [SCALE_W-1:0] RATE_MAX    = 22'h3FFFFF;
endpackage
`default_nettype wire

// ===== sv/csm_div.sv =====
// Bit-serial restoring divider, one quotient bit per cycle.
`default_nettype none
module csm_div #(
  parameter int DIVIDEND_W = 22,
  parameter int DIVISOR_W  = 16
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  start,
  input  wire logic [DIVIDEND_W-1:0] dividend,
  input  wire logic [DIVISOR_W-1:0]  divisor,
  output logic                       done,
  output logic [DIVIDEND_W-1:0]      quotient
);
  localparam int CNT_W = (DIVIDEND_W > 1) ? $clog2(DIVIDEND_W) : 1;

  logic                  busy;
  logic [CNT_W-1:0]      cnt;
  logic [DIVISOR_W-1:0]  divisor_r;
  logic [DIVISOR_W-1:0]  rem;
  logic [DIVIDEND_W-1:0] quo;

  logic [DIVISOR_W:0]    shifted;
  logic [DIVISOR_W:0]    diff;
  logic                  ge;

  // The single compare-and-subtract unit shared by every iteration.
  always_comb begin
    shifted = {rem, quo[DIVIDEND_W-1]};
    ge      = (shifted >= {1'b0, divisor_r});
    diff    = shifted - {1'b0, divisor_r};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy      <= 1'b1;
        cnt       <= CNT_W'(DIVIDEND_W - 1);
        divisor_r <= divisor;
        rem       <= '0;
        quo       <= dividend;
      end else if (busy) begin
        rem <= ge ? diff[DIVISOR_W-1:0] : shifted[DIVISOR_W-1:0];
        quo <= {quo[DIVIDEND_W-2:0], ge};
        cnt <= cnt - CNT_W'(1);
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign quotient = quo;
endmodule
`default_nettype wire

// ===== sv/capture_period_speed_meter.sv =====
// Flow: an edge that gives a rate runs the bit-serial divider (one quotient bit per cycle),
// then the quotient is collected into the pending result and that result is loaded into the
// output register. Any other edge, or a zero period, skips the divider and goes to the output register.
// Throughput: one transaction at a time; the input stalls until the result is in the output
// register, and a stalled output register holds it back longer.
// Reset (synchronous, active high): previous capture and edge parity clear, the scale
// returns to 3003003, and the output register empties.
`default_nettype none
module capture_period_speed_meter #(
  parameter int TIMER_BITS = csm_pkg::TIMER_BITS_DEFAULT
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  // Scale register write port.
  input  wire logic                         scale_we,
  input  wire logic [csm_pkg::SCALE_W-1:0]  scale_wdata,
  // Capture input channel.
  input  wire logic                         in_valid,
  output logic                              in_stall,
  input  wire logic [csm_pkg::CAP_W-1:0]    capture_value,
  // Result channel.
  output logic                              out_valid,
  input  wire logic                         out_stall,
  output logic [csm_pkg::CAP_W-1:0]         period_ticks,
  output logic                              rate_valid,
  output logic [csm_pkg::SCALE_W-1:0]       rate_value,
  output logic                              zero_period
);
  import csm_pkg::*;

  `include "capture_period_speed_meter_assert.svh"

  // Only the low timer bits of a capture matter, and no more than the port carries.
  localparam int KEEP_W = (TIMER_BITS < CAP_W) ? TIMER_BITS : CAP_W;

  // The sequencer: take an edge, run the divider when a rate is due, then hand the
  // finished transaction to the output register as soon as it has room.
  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_DIV  = 3'b010,
    S_DONE = 3'b100
  } state_t;

  state_t               state;
  logic [SCALE_W-1:0]   scale;
  logic [KEEP_W-1:0]    prev;
  logic                 parity;

  // Result being assembled for the current edge.
  logic [CAP_W-1:0]     pend_period;
  logic                 pend_valid;
  logic [SCALE_W-1:0]   pend_rate;
  logic                 pend_zero;

  logic [KEEP_W-1:0]    cap;
  logic [TIMER_BITS-1:0] period;
  logic                 period_zero;
  logic                 rate_edge;
  logic                 in_take;
  logic                 out_free;
  logic                 out_load;
  logic                 div_start;
  logic                 div_done;
  logic [SCALE_W-1:0]   div_quo;

  // The period is a plain subtraction modulo 2^TIMER_BITS, so timer wrap needs no care.
  always_comb begin
    cap         = capture_value[KEEP_W-1:0];
    period      = TIMER_BITS'(cap) - TIMER_BITS'(prev);
    period_zero = (period == '0);
    // Parity is 0 before odd edges; the edge that brings it back to 0 gives a rate.
    rate_edge   = parity;
  end

  assign in_stall  = (state != S_IDLE);
  assign in_take   = in_valid && !in_stall;
  assign out_free  = !out_valid || !out_stall;
  // The output register takes a finished transaction whenever it is empty or being read.
  assign out_load  = (state == S_DONE) && out_free;
  assign div_start = in_take && rate_edge && !period_zero;

  csm_div #(
    .DIVIDEND_W (SCALE_W),
    .DIVISOR_W  (TIMER_BITS)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (scale),
    .divisor  (period),
    .done     (div_done),
    .quotient (div_quo)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      scale     <= SCALE_RESET;
      prev      <= '0;
      parity    <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (scale_we) begin
        scale <= scale_wdata;
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_take) begin
            prev        <= cap;
            parity      <= !parity;
            pend_period <= CAP_W'(period);
            pend_valid  <= rate_edge;
            // A zero period on a rate edge saturates; an odd edge gives no rate.
            pend_zero   <= rate_edge && period_zero;
            pend_rate   <= (rate_edge && period_zero) ? RATE_MAX : '0;
            state       <= div_start ? S_DIV : S_DONE;
          end
        end
        S_DIV: begin
          if (div_done) begin
            pend_rate <= div_quo;
            state     <= S_DONE;
          end
        end
        S_DONE: begin
          if (out_free) begin
            period_ticks <= pend_period;
            rate_valid   <= pend_valid;
            rate_value   <= pend_rate;
            zero_period  <= pend_zero;
            state        <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // An accepted edge always holds off the next one, as the sequencer leaves idle.
  `CSM_ASSERT_NXT(a_take_blocks, clk, rst, in_take, in_stall)
  // Edges without a rate carry neither a rate nor the zero flag.
  `CSM_ASSERT_IMP(a_no_rate_clean, clk, rst, out_valid && !rate_valid,
                  rate_value == '0 && !zero_period)
  // The zero flag comes only with a saturated rate on a zero period.
  `CSM_ASSERT_IMP(a_zero_sat, clk, rst, out_valid && zero_period,
                  rate_valid && rate_value == RATE_MAX && period_ticks == '0)
  // The divider finishes only while the sequencer waits for it.
  `CSM_ASSERT_IMP(a_div_owned, clk, rst, div_done, state == S_DIV)
endmodule
`default_nettype wire
